/* rtl/core/blr_pkg.sv */
// ----------------------------------------------------------------------------
// Bresenham line rasterizer package
// Opcodes, register indexes, reset values and fixed field widths.
// ----------------------------------------------------------------------------
package blr_pkg;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } opcode_type;

   localparam int PITCH_BITS     = 16;
   localparam int BASE_BITS      = 24;
   localparam int COLOR_BITS     = 32;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 24;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_PITCH  = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_BASE = 4'd1;

   localparam logic [PITCH_BITS-1:0] ROW_PITCH_RESET  = 16'd1024;
   localparam logic [BASE_BITS-1:0]  FRAME_BASE_RESET = 24'd0;

endpackage

/* rtl/core/blr_if.sv */
// ----------------------------------------------------------------------------
// Bresenham line rasterizer channels
// Command, pixel write and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface blr_req_if import blr_pkg::*; #(
   parameter int COORD_BITS = 12
);
   logic                  valid;
   logic                  ready;
   opcode_type            opcode;
   logic [COORD_BITS-1:0] start_x;
   logic [COORD_BITS-1:0] start_y;
   logic [COORD_BITS-1:0] end_x;
   logic [COORD_BITS-1:0] end_y;
   logic [COLOR_BITS-1:0] line_color;

   modport source (output valid, opcode, start_x, start_y, end_x, end_y, line_color,
                   input ready);
   modport sink   (input valid, opcode, start_x, start_y, end_x, end_y, line_color,
                   output ready);
endinterface

interface blr_rsp_if import blr_pkg::*; #(
   parameter int COORD_BITS = 12,
   parameter int ADDR_BITS  = 24
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   logic [ADDR_BITS-1:0]  pixel_addr;
   logic [COLOR_BITS-1:0] pixel_color;
   logic                  last_pixel;

   modport source (output valid, pixel_x, pixel_y, pixel_addr, pixel_color, last_pixel,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_addr, pixel_color, last_pixel,
                   output ready);
endinterface

interface blr_csr_if import blr_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/blr_stepper.sv */
// ----------------------------------------------------------------------------
// Bresenham line stepper
// Holds the line state, takes command beats and issues one pixel per step.
// ----------------------------------------------------------------------------
module blr_stepper import blr_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   blr_req_if.sink                          req_bus,
   input  logic [PITCH_BITS-1:0]            row_pitch,
   input  logic                             down_ready,
   output logic                             pix_valid,
   output logic [COORD_BITS-1:0]            pix_x,
   output logic [COORD_BITS-1:0]            pix_y,
   output logic [COORD_BITS+PITCH_BITS-1:0] pix_prod,
   output logic [COLOR_BITS-1:0]            pix_color,
   output logic                             pix_last
);

   localparam int DELTA_W = COORD_BITS + 1;
   localparam int ERR_W   = COORD_BITS + 3;
   localparam int PROD_W  = COORD_BITS + PITCH_BITS;

   logic                     active_ff, active_in;
   logic [COORD_BITS-1:0]    cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0]    cur_y_ff, cur_y_in;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic [COORD_BITS:0]      left_ff, left_in;
   logic [COORD_BITS-1:0]    major_ff, major_in;
   logic [COORD_BITS-1:0]    minor_ff, minor_in;
   logic                     x_major_ff, x_major_in;
   logic                     x_neg_ff, x_neg_in;
   logic                     y_neg_ff, y_neg_in;
   logic [COLOR_BITS-1:0]    color_ff, color_in;

   logic                     pix_valid_ff, pix_valid_in;
   logic [COORD_BITS-1:0]    pix_x_ff, pix_x_in;
   logic [COORD_BITS-1:0]    pix_y_ff, pix_y_in;
   logic [PROD_W-1:0]        pix_prod_ff, pix_prod_in;
   logic [COLOR_BITS-1:0]    pix_color_ff, pix_color_in;
   logic                     pix_last_ff, pix_last_in;

   logic                     stage_ready;
   logic                     accept;
   logic [DELTA_W-1:0]       dx, dy, adx_full, ady_full;
   logic                     dx_neg, dy_neg, load_x_major;
   logic [COORD_BITS-1:0]    adx, ady, load_major, load_minor;
   logic signed [ERR_W-1:0]  load_err;
   logic                     err_ge;
   logic signed [ERR_W-1:0]  major2, minor2, major_sub;
   logic [COORD_BITS-1:0]    x_step, y_step;

   assign stage_ready   = !pix_valid_ff || down_ready;
   assign req_bus.ready = stage_ready;
   assign accept        = req_bus.valid && stage_ready;

   assign dx       = {1'b0, req_bus.end_x} - {1'b0, req_bus.start_x};
   assign dy       = {1'b0, req_bus.end_y} - {1'b0, req_bus.start_y};
   assign dx_neg   = dx[DELTA_W-1];
   assign dy_neg   = dy[DELTA_W-1];
   assign adx_full = dx_neg ? (~dx + 1'b1) : dx;
   assign ady_full = dy_neg ? (~dy + 1'b1) : dy;
   assign adx      = adx_full[COORD_BITS-1:0];
   assign ady      = ady_full[COORD_BITS-1:0];

   assign load_x_major = adx > ady;
   assign load_major   = load_x_major ? adx : ady;
   assign load_minor   = load_x_major ? ady : adx;
   assign load_err     = $signed({2'b00, load_minor, 1'b0}) - $signed({3'b000, load_major});

   assign err_ge    = !err_ff[ERR_W-1];
   assign major2    = $signed({2'b00, major_ff, 1'b0});
   assign minor2    = $signed({2'b00, minor_ff, 1'b0});
   assign major_sub = err_ge ? major2 : '0;
   assign x_step    = x_neg_ff ? (cur_x_ff - 1'b1) : (cur_x_ff + 1'b1);
   assign y_step    = y_neg_ff ? (cur_y_ff - 1'b1) : (cur_y_ff + 1'b1);

   always_comb begin
      active_in    = active_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      err_in       = err_ff;
      left_in      = left_ff;
      major_in     = major_ff;
      minor_in     = minor_ff;
      x_major_in   = x_major_ff;
      x_neg_in     = x_neg_ff;
      y_neg_in     = y_neg_ff;
      color_in     = color_ff;
      pix_valid_in = pix_valid_ff;
      pix_x_in     = pix_x_ff;
      pix_y_in     = pix_y_ff;
      pix_prod_in  = pix_prod_ff;
      pix_color_in = pix_color_ff;
      pix_last_in  = pix_last_ff;

      if (stage_ready) begin
         pix_valid_in = 1'b0;
      end

      if (accept) begin
         if (req_bus.opcode == OP_LOAD) begin
            active_in  = 1'b1;
            cur_x_in   = req_bus.start_x;
            cur_y_in   = req_bus.start_y;
            err_in     = load_err;
            left_in    = {1'b0, load_major} + 1'b1;
            major_in   = load_major;
            minor_in   = load_minor;
            x_major_in = load_x_major;
            x_neg_in   = dx_neg;
            y_neg_in   = dy_neg;
            color_in   = req_bus.line_color;
         end else if (active_ff) begin
            pix_valid_in = 1'b1;
            pix_x_in     = cur_x_ff;
            pix_y_in     = cur_y_ff;
            pix_prod_in  = PROD_W'(cur_y_ff) * PROD_W'(row_pitch);
            pix_color_in = color_ff;
            pix_last_in  = (left_ff == 1'b1);

            err_in = err_ff - major_sub + minor2;
            if (x_major_ff) begin
               cur_x_in = x_step;
               if (err_ge) begin
                  cur_y_in = y_step;
               end
            end else begin
               cur_y_in = y_step;
               if (err_ge) begin
                  cur_x_in = x_step;
               end
            end
            left_in   = left_ff - 1'b1;
            active_in = (left_ff != 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         pix_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         pix_valid_ff <= pix_valid_in;
      end
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      err_ff       <= err_in;
      left_ff      <= left_in;
      major_ff     <= major_in;
      minor_ff     <= minor_in;
      x_major_ff   <= x_major_in;
      x_neg_ff     <= x_neg_in;
      y_neg_ff     <= y_neg_in;
      color_ff     <= color_in;
      pix_x_ff     <= pix_x_in;
      pix_y_ff     <= pix_y_in;
      pix_prod_ff  <= pix_prod_in;
      pix_color_ff <= pix_color_in;
      pix_last_ff  <= pix_last_in;
   end

   assign pix_valid = pix_valid_ff;
   assign pix_x     = pix_x_ff;
   assign pix_y     = pix_y_ff;
   assign pix_prod  = pix_prod_ff;
   assign pix_color = pix_color_ff;
   assign pix_last  = pix_last_ff;

   a_load_arms: assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.opcode == OP_LOAD |=> active_ff)
      else $error("load beat did not start a line");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.opcode == OP_STEP && active_ff && left_ff == 1'b1
      |=> !active_ff && pix_valid_ff && pix_last_ff)
      else $error("final pixel did not end the line");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      pix_valid_ff && !down_ready |=> pix_valid_ff && $stable(pix_x_ff) && $stable(pix_y_ff))
      else $error("stalled pixel changed");

endmodule

/* rtl/core/blr_addr_gen.sv */
// ----------------------------------------------------------------------------
// Bresenham line address generator
// Adds frame base, row product and x, and holds the pixel write beat.
// ----------------------------------------------------------------------------
module blr_addr_gen import blr_pkg::*; #(
   parameter int COORD_BITS = 12,
   parameter int ADDR_BITS  = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [BASE_BITS-1:0]             frame_base,
   input  logic                             pix_valid,
   input  logic [COORD_BITS-1:0]            pix_x,
   input  logic [COORD_BITS-1:0]            pix_y,
   input  logic [COORD_BITS+PITCH_BITS-1:0] pix_prod,
   input  logic [COLOR_BITS-1:0]            pix_color,
   input  logic                             pix_last,
   output logic                             up_ready,
   blr_rsp_if.source                        rsp_bus
);

   localparam int PROD_W = COORD_BITS + PITCH_BITS;
   localparam int MAX_AP = (ADDR_BITS > PROD_W) ? ADDR_BITS : PROD_W;
   localparam int SUM_W  = ((MAX_AP > BASE_BITS) ? MAX_AP : BASE_BITS) + 2;

   logic                  valid_ff, valid_in;
   logic [COORD_BITS-1:0] x_ff, x_in;
   logic [COORD_BITS-1:0] y_ff, y_in;
   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;
   logic                  last_ff, last_in;
   logic [SUM_W-1:0]      sum;

   assign up_ready = !valid_ff || rsp_bus.ready;
   assign sum      = SUM_W'(frame_base) + SUM_W'(pix_prod) + SUM_W'(pix_x);

   always_comb begin
      valid_in = valid_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      addr_in  = addr_ff;
      color_in = color_ff;
      last_in  = last_ff;
      if (up_ready) begin
         valid_in = pix_valid;
         x_in     = pix_x;
         y_in     = pix_y;
         addr_in  = sum[ADDR_BITS-1:0];
         color_in = pix_color;
         last_in  = pix_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      x_ff     <= x_in;
      y_ff     <= y_in;
      addr_ff  <= addr_in;
      color_ff <= color_in;
      last_ff  <= last_in;
   end

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.pixel_x     = x_ff;
   assign rsp_bus.pixel_y     = y_ff;
   assign rsp_bus.pixel_addr  = addr_ff;
   assign rsp_bus.pixel_color = color_ff;
   assign rsp_bus.last_pixel  = last_ff;

   a_take_pixel: assert property (@(posedge clock) disable iff (reset)
      pix_valid && up_ready |=> valid_ff && x_ff == $past(pix_x) && y_ff == $past(pix_y))
      else $error("pixel lost between stages");

   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      !pix_valid && up_ready |=> !valid_ff)
      else $error("pixel write without a source pixel");

endmodule

/* rtl/core/bresenham_line_rasterizer_unit.sv */
// ----------------------------------------------------------------------------
// Bresenham line rasterizer unit
// Integer line stepper with frame buffer address generation.
//
//   channel   dir   beat
//   req_bus   in    load (endpoints, color) or step
//   rsp_bus   out   pixel write: x, y, word address, color, last flag
//   csr_bus   in    register write: row pitch, frame base
//
// One command beat per cycle is taken unless rsp_bus stalls; a step beat
// gives its pixel write via the line state stage, then the address add stage.
// Loads give no pixel; a step with no line in progress gives none either.
// Reset clears line state; row pitch returns to 1024 and frame base to 0.
// Both stages hold under rsp_bus stall and back-pressure req_bus in turn.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_unit import blr_pkg::*; #(
   parameter int COORD_BITS = 12,
   parameter int ADDR_BITS  = 24
) (
   input  logic      clock,
   input  logic      reset,
   blr_req_if.sink   req_bus,
   blr_rsp_if.source rsp_bus,
   blr_csr_if.sink   csr_bus
);

   localparam int PROD_W = COORD_BITS + PITCH_BITS;

   logic [PITCH_BITS-1:0] row_pitch_ff, row_pitch_in;
   logic [BASE_BITS-1:0]  frame_base_ff, frame_base_in;

   logic                  pix_valid;
   logic [COORD_BITS-1:0] pix_x;
   logic [COORD_BITS-1:0] pix_y;
   logic [PROD_W-1:0]     pix_prod;
   logic [COLOR_BITS-1:0] pix_color;
   logic                  pix_last;
   logic                  down_ready;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      row_pitch_in  = row_pitch_ff;
      frame_base_in = frame_base_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_ROW_PITCH: begin
               row_pitch_in = csr_bus.data[PITCH_BITS-1:0];
            end
            CSR_FRAME_BASE: begin
               frame_base_in = csr_bus.data[BASE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pitch_ff  <= ROW_PITCH_RESET;
         frame_base_ff <= FRAME_BASE_RESET;
      end else begin
         row_pitch_ff  <= row_pitch_in;
         frame_base_ff <= frame_base_in;
      end
   end

   blr_stepper #(
      .COORD_BITS (COORD_BITS)
   ) u_stepper (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .row_pitch  (row_pitch_ff),
      .down_ready (down_ready),
      .pix_valid  (pix_valid),
      .pix_x      (pix_x),
      .pix_y      (pix_y),
      .pix_prod   (pix_prod),
      .pix_color  (pix_color),
      .pix_last   (pix_last)
   );

   blr_addr_gen #(
      .COORD_BITS (COORD_BITS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_addr_gen (
      .clock      (clock),
      .reset      (reset),
      .frame_base (frame_base_ff),
      .pix_valid  (pix_valid),
      .pix_x      (pix_x),
      .pix_y      (pix_y),
      .pix_prod   (pix_prod),
      .pix_color  (pix_color),
      .pix_last   (pix_last),
      .up_ready   (down_ready),
      .rsp_bus    (rsp_bus)
   );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bresenham line rasterizer unit testbench
// Drives load and step beats with random gaps against a stalling pixel
// sink and checks every pixel write against a line stepper kept in the
// bench. The row pitch and frame base are changed between phases while
// the unit is idle, including the extreme settings and address wrap.
// ----------------------------------------------------------------------------
module testbench import blr_pkg::*;;

   localparam int COORD_BITS   = 12;
   localparam int ADDR_BITS    = 24;
   localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
   localparam int DRAIN_CYCLES = 6;
   localparam int CYCLE_LIMIT  = 400000;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 4'hF;

   typedef struct {
      opcode_type            op;
      logic [COORD_BITS-1:0] sx;
      logic [COORD_BITS-1:0] sy;
      logic [COORD_BITS-1:0] ex;
      logic [COORD_BITS-1:0] ey;
      logic [COLOR_BITS-1:0] color;
   } line_cmd_type;

   typedef struct {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [ADDR_BITS-1:0]  addr;
      logic [COLOR_BITS-1:0] color;
      logic                  last;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   blr_req_if #(.COORD_BITS(COORD_BITS)) req_bus ();
   blr_rsp_if #(.COORD_BITS(COORD_BITS), .ADDR_BITS(ADDR_BITS)) rsp_bus ();
   blr_csr_if csr_bus ();

   bresenham_line_rasterizer_unit #(
      .COORD_BITS(COORD_BITS),
      .ADDR_BITS (ADDR_BITS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   line_cmd_type command_queue[$];
   pixel_type    expected_pixels[$];

   // line stepper state and register copies
   logic [PITCH_BITS-1:0] reg_pitch = ROW_PITCH_RESET;
   logic [BASE_BITS-1:0]  reg_base  = FRAME_BASE_RESET;
   logic                  line_active  = 1'b0;
   logic [COORD_BITS-1:0] line_x       = '0;
   logic [COORD_BITS-1:0] line_y       = '0;
   int                    line_err     = 0;
   int                    line_left    = 0;
   int                    line_major   = 0;
   int                    line_minor   = 0;
   logic                  line_x_major = 1'b0;
   logic                  line_x_neg   = 1'b0;
   logic                  line_y_neg   = 1'b0;
   logic [COLOR_BITS-1:0] pen_color    = '0;

   int error_count    = 0;
   int commands_sent  = 0;
   int pixels_checked = 0;
   int settings_used  = 1;
   int cycle_count    = 0;
   int tx_wait_max    = 0;
   int rx_wait_max    = 0;

   function automatic int draw_wait(int max_wait);
      if (max_wait == 0 || $urandom_range(1, 0) == 0)
         return 0;
      return $urandom_range(max_wait, 0);
   endfunction

   // advance the line state by one beat and queue the pixel it emits
   function automatic void rasterize_beat(line_cmd_type c);
      int          dx;
      int          dy;
      pixel_type   px;
      logic [63:0] full_addr;
      if (c.op == OP_LOAD) begin
         dx = int'(c.ex) - int'(c.sx);
         dy = int'(c.ey) - int'(c.sy);
         line_x_neg = dx < 0;
         line_y_neg = dy < 0;
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         line_x_major = dx > dy;
         line_major   = line_x_major ? dx : dy;
         line_minor   = line_x_major ? dy : dx;
         line_err     = 2 * line_minor - line_major;
         line_left    = line_major + 1;
         line_x       = c.sx;
         line_y       = c.sy;
         pen_color    = c.color;
         line_active  = 1'b1;
      end else if (line_active) begin
         full_addr = 64'(reg_base) + 64'(line_y) * 64'(reg_pitch) + 64'(line_x);
         px.x     = line_x;
         px.y     = line_y;
         px.addr  = full_addr[ADDR_BITS-1:0];
         px.color = pen_color;
         px.last  = (line_left == 1);
         expected_pixels.push_back(px);
         if (line_err >= 0) begin
            line_err -= 2 * line_major;
            if (line_x_major)
               line_y = line_y_neg ? line_y - 1'b1 : line_y + 1'b1;
            else
               line_x = line_x_neg ? line_x - 1'b1 : line_x + 1'b1;
         end
         line_err += 2 * line_minor;
         if (line_x_major)
            line_x = line_x_neg ? line_x - 1'b1 : line_x + 1'b1;
         else
            line_y = line_y_neg ? line_y - 1'b1 : line_y + 1'b1;
         line_left--;
         if (line_left == 0)
            line_active = 1'b0;
      end
   endfunction

   // command driver
   line_cmd_type tx_cmd;
   int           tx_wait = 0;

   always @(posedge clock) begin
      logic beat;
      if (reset) begin
         req_bus.valid <= 1'b0;
         tx_wait = 0;
      end else begin
         beat = req_bus.valid && req_bus.ready;
         if (beat) begin
            rasterize_beat(tx_cmd);
            commands_sent++;
            tx_wait = draw_wait(tx_wait_max);
         end else if (!req_bus.valid && tx_wait > 0) begin
            tx_wait--;
         end
         if (!req_bus.valid || beat) begin
            if (tx_wait == 0 && command_queue.size() != 0) begin
               tx_cmd = command_queue.pop_front();
               req_bus.opcode     <= tx_cmd.op;
               req_bus.start_x    <= tx_cmd.sx;
               req_bus.start_y    <= tx_cmd.sy;
               req_bus.end_x      <= tx_cmd.ex;
               req_bus.end_y      <= tx_cmd.ey;
               req_bus.line_color <= tx_cmd.color;
               req_bus.valid      <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // pixel monitor
   int rx_wait = 0;

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rx_wait = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_pixels.size() == 0) begin
               $error("pixel write beat with no pixel expected: x %0d y %0d",
                      rsp_bus.pixel_x, rsp_bus.pixel_y);
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               pixels_checked++;
               if (rsp_bus.pixel_x !== want.x) begin
                  $error("pixel_x expected %0d got %0d", want.x, rsp_bus.pixel_x);
                  error_count++;
               end
               if (rsp_bus.pixel_y !== want.y) begin
                  $error("pixel_y expected %0d got %0d", want.y, rsp_bus.pixel_y);
                  error_count++;
               end
               if (rsp_bus.pixel_addr !== want.addr) begin
                  $error("pixel_addr expected %h got %h", want.addr, rsp_bus.pixel_addr);
                  error_count++;
               end
               if (rsp_bus.pixel_color !== want.color) begin
                  $error("pixel_color expected %h got %h", want.color, rsp_bus.pixel_color);
                  error_count++;
               end
               if (rsp_bus.last_pixel !== want.last) begin
                  $error("last_pixel expected %0d got %0d", want.last, rsp_bus.last_pixel);
                  error_count++;
               end
            end
            rx_wait = draw_wait(rx_wait_max);
         end else if (rx_wait > 0) begin
            rx_wait--;
         end
         rsp_bus.ready <= (rx_wait == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic push_cmd(opcode_type op, int sx, int sy, int ex, int ey,
                           logic [COLOR_BITS-1:0] color);
      line_cmd_type c;
      c.op    = op;
      c.sx    = sx[COORD_BITS-1:0];
      c.sy    = sy[COORD_BITS-1:0];
      c.ex    = ex[COORD_BITS-1:0];
      c.ey    = ey[COORD_BITS-1:0];
      c.color = color;
      command_queue.push_back(c);
   endtask

   task automatic push_steps(int count);
      repeat (count)
         push_cmd(OP_STEP, $urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0),
                  $urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0), $urandom());
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (idx == CSR_ROW_PITCH)
         reg_pitch = value[PITCH_BITS-1:0];
      else if (idx == CSR_FRAME_BASE)
         reg_base = value[BASE_BITS-1:0];
   endtask

   task automatic set_frame(logic [PITCH_BITS-1:0] pitch, logic [BASE_BITS-1:0] base);
      write_reg(CSR_ROW_PITCH, {8'($urandom()), pitch});
      write_reg(CSR_FRAME_BASE, base);
      settings_used++;
   endtask

   // hold until every queued beat is taken and every pixel has come back
   task automatic wait_drained();
      do @(negedge clock);
      while (command_queue.size() != 0 || req_bus.valid || expected_pixels.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // mostly complete short lines with random payload, some aborted, some
   // overrun into idle steps, a few long lines cut short, and some noise
   task automatic queue_random_lines(int budget);
      int made;
      int sx, sy, ex, ey;
      int major, dx, dy, steps, pick;
      made = 0;
      while (made < budget) begin
         if ($urandom_range(9, 0) < 8) begin
            sx = $urandom_range(COORD_MAX, 0);
            sy = $urandom_range(COORD_MAX, 0);
            if ($urandom_range(15, 0) == 0) begin
               ex = $urandom_range(COORD_MAX, 0);
               ey = $urandom_range(COORD_MAX, 0);
            end else begin
               ex = $urandom_range(sx > COORD_MAX - 15 ? COORD_MAX : sx + 15,
                                   sx < 15 ? 0 : sx - 15);
               ey = $urandom_range(sy > COORD_MAX - 15 ? COORD_MAX : sy + 15,
                                   sy < 15 ? 0 : sy - 15);
            end
            push_cmd(OP_LOAD, sx, sy, ex, ey, $urandom());
            dx = ex > sx ? ex - sx : sx - ex;
            dy = ey > sy ? ey - sy : sy - ey;
            major = dx > dy ? dx : dy;
            steps = major + 1;
            pick = $urandom_range(9, 0);
            if (pick == 0)
               steps = $urandom_range(major, 0);
            else if (pick == 1)
               steps += $urandom_range(3, 1);
            if (steps > 40)
               steps = $urandom_range(40, 1);
            push_steps(steps);
            made += steps + 1;
         end else begin
            if ($urandom_range(1, 0) == 0) begin
               push_steps(1);
            end else begin
               push_cmd(OP_LOAD, $urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0),
                        $urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0),
                        $urandom());
            end
            made++;
         end
      end
   endtask

   task automatic run_phase(int tx_max, int rx_max, int budget);
      tx_wait_max = tx_max;
      rx_wait_max = rx_max;
      queue_random_lines(budget);
      wait_drained();
   endtask

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.opcode     = OP_STEP;
      req_bus.start_x    = '0;
      req_bus.start_y    = '0;
      req_bus.end_x      = '0;
      req_bus.end_y      = '0;
      req_bus.line_color = '0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = CSR_ROW_PITCH;
      csr_bus.data       = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed lines at reset register values
      tx_wait_max = 13;
      rx_wait_max = 13;
      push_steps(2);
      push_cmd(OP_LOAD, 0, 0, 0, 0, 32'h0000_0000);
      push_steps(2);
      push_cmd(OP_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF);
      push_steps(1);
      push_cmd(OP_LOAD, 0, COORD_MAX, COORD_MAX, 0, 32'hA5A5_5A5A);
      push_steps(3);
      push_cmd(OP_LOAD, COORD_MAX, 0, 0, 1, 32'h1234_5678);
      push_steps(2);
      push_cmd(OP_LOAD, 5, 5, 5, 2, 32'hDEAD_BEEF);
      push_steps(5);
      push_cmd(OP_LOAD, 1, 1, 4, 2, 32'h8000_0001);
      push_steps(4);
      wait_drained();

      run_phase(13, 13, 190);
      set_frame(16'hFFFF, 24'hFFFFFF);
      run_phase(0, 0, 190);
      set_frame(16'h0000, 24'h000000);
      run_phase(13, 0, 185);
      write_reg(CSR_UNMAPPED, 24'hFFFFFF);
      set_frame(16'h0001, 24'hFFFFF0);
      run_phase(0, 13, 185);
      set_frame(16'($urandom()), 24'($urandom()));
      run_phase(13, 13, 185);
      set_frame(16'($urandom()), 24'($urandom()));
      run_phase(5, 13, 185);

      $display("%0d command beats driven, %0d pixel writes checked", commands_sent,
               pixels_checked);
      $display("%0d frame settings, lines in all octants with aborts and idle steps",
               settings_used);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
